// File: rtl/iwcs_pkg.sv
`timescale 1ns / 1ps
package iwcs_pkg;
   localparam int GRID_POINTS_DEF = 256;
   localparam int MAX_PROCESSES_DEF = 32;
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_LOAD_FREQ = 2'd1;
   localparam logic [1:0] OP_LOAD_ENERGY = 2'd2;
   localparam logic [1:0] OP_LOAD_THRESH = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] electron_energy;
      logic [31:0] random_draw;
      logic [7:0]  point_index;
      logic [4:0]  process_index;
      logic [31:0] table_word;
   } req_type;

   typedef struct packed {
      logic [4:0] selected_process;
      logic       null_collision;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic load;
      logic grid_rd;
      logic grid_step;
      logic div_start;
      logic div_step;
      logic proc_start;
      logic proc_rd;
      logic proc_acc;
   } cmd_type;

   typedef struct packed {
      logic below;
      logic above;
      logic grid_found;
      logic div_last;
      logic proc_done;
   } sts_type;
endpackage

// File: rtl/interp_weighted_collision_select.sv
`timescale 1ns / 1ps
// Sample flow: after acceptance the grid walk stops at the bracket, the 16-step divider
// forms the weight, and each process takes one read and one accumulate; the result
// transaction is then held until rsp_stall is low.
// One transaction in flight at a time; loads are accepted only while idle.
// Reset: synchronous, active high; the active-process count n_ff returns to 1, tables undefined.
module interp_weighted_collision_select import iwcs_pkg::*; #(
   parameter int GRID_POINTS = GRID_POINTS_DEF,
   parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [5:0] csr_data
);
   logic [5:0] n_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) n_ff <= 6'd1;
      else if (csr_valid) n_ff <= csr_data;
   end

   iwcs_control #(.GRID_POINTS(GRID_POINTS)) u_ctrl (
      .clock, .reset, .req_valid, .req_op(req_data.operation), .req_stall,
      .rsp_valid, .rsp_stall, .sts, .cmd);

   iwcs_datapath #(.GRID_POINTS(GRID_POINTS), .MAX_PROCESSES(MAX_PROCESSES)) u_dp (
      .clock, .req(req_data), .n_active(n_ff), .cmd, .sts, .result(rsp_data));

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted during output");
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.null_collision |-> rsp_data.selected_process == 5'd0)
      else $error("null with index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
`endif
endmodule

// File: rtl/iwcs_datapath.sv
`timescale 1ns / 1ps
module iwcs_datapath import iwcs_pkg::*; #(
   parameter int GRID_POINTS = GRID_POINTS_DEF,
   parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
   input  logic    clock,
   input  req_type req,
   input  logic [5:0] n_active,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type result
);
   localparam int GW = $clog2(GRID_POINTS);
   localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int PC = $clog2(MAX_PROCESSES + 1);
   localparam int FW = $clog2(GRID_POINTS * MAX_PROCESSES);

   logic [31:0] fmem [GRID_POINTS*MAX_PROCESSES];
   logic [31:0] gmem [GRID_POINTS];
   logic [31:0] tmem [MAX_PROCESSES];

   req_type     item_ff;
   logic [31:0] g_rd_ff, g_first_ff, g_last_ff, g_lo_ff;
   logic [GW-1:0] gi_ff;
   logic [GW-1:0] lo_ff, hi_ff;
   logic [32:0] rem_ff;
   logic [31:0] den_ff;
   logic [15:0] w_ff;
   logic [4:0]  dcnt_ff;
   logic [PC-1:0] p_ff;
   logic [PC-1:0] n_eff;
   logic [31:0] flo_ff, fhi_ff, th_ff;
   logic        rd_ok_ff;
   logic [PW-1:0] prd_ff;
   logic [63:0] sum_ff;
   logic        done_ff;
   rsp_type     res_ff;
   logic [GW-1:0] gaddr;
   logic [PW-1:0] paddr;
   logic [FW-1:0] faddr_ld, faddr_lo, faddr_hi;
   logic [47:0] prod_lo, prod_hi;
   logic [63:0] sum_in;
   logic [32:0] trial;

   assign faddr_ld = FW'(32'(req.point_index) * MAX_PROCESSES + 32'(req.process_index));
   assign faddr_lo = FW'(32'(lo_ff) * MAX_PROCESSES + 32'(paddr));
   assign faddr_hi = FW'(32'(hi_ff) * MAX_PROCESSES + 32'(paddr));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (req.operation == OP_LOAD_FREQ && 32'(req.point_index) < GRID_POINTS
             && 32'(req.process_index) < MAX_PROCESSES)
            fmem[faddr_ld] <= req.table_word;
         if (req.operation == OP_LOAD_ENERGY && 32'(req.point_index) < GRID_POINTS)
            gmem[GW'(req.point_index)] <= req.table_word;
         if (req.operation == OP_LOAD_THRESH && 32'(req.process_index) < MAX_PROCESSES)
            tmem[PW'(req.process_index)] <= req.table_word;
      end
   end

   assign gaddr = cmd.start ? GW'(0) : (cmd.grid_step ? gi_ff : gi_ff - GW'(1));
   assign paddr = PW'(p_ff);
   assign n_eff = (32'(n_active) > MAX_PROCESSES) ? PC'(MAX_PROCESSES) : PC'(n_active);

   always_ff @(posedge clock) begin
      g_rd_ff <= gmem[gaddr];
      g_last_ff <= gmem[GW'(GRID_POINTS - 1)];
      flo_ff <= fmem[faddr_lo];
      fhi_ff <= fmem[faddr_hi];
      th_ff <= tmem[paddr];
   end

   assign trial = {rem_ff[31:0], 1'b0} - {1'b0, den_ff};
   assign prod_lo = 48'(flo_ff) * 48'(17'h10000 - 17'(w_ff));
   assign prod_hi = 48'(fhi_ff) * 48'(w_ff);
   assign sum_in = sum_ff + ((th_ff <= item_ff.electron_energy) ?
      64'((prod_lo + prod_hi) >> 16) : 64'd0);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req;
         gi_ff <= GW'(1);
         g_lo_ff <= '0;
      end
      if (cmd.grid_rd) begin
         if (gi_ff == GW'(1)) g_first_ff <= g_rd_ff;
      end
      if (cmd.grid_step) begin
         if (!sts.grid_found) g_lo_ff <= g_rd_ff;
         gi_ff <= gi_ff + GW'(1);
      end
      if (cmd.div_start) begin
         if (sts.below || sts.above) begin
            lo_ff <= sts.below ? GW'(0) : GW'(GRID_POINTS - 1);
            hi_ff <= sts.below ? GW'(0) : GW'(GRID_POINTS - 1);
            den_ff <= 32'd1;
            rem_ff <= '0;
         end else begin
            lo_ff <= gi_ff - GW'(2);
            hi_ff <= gi_ff - GW'(1);
            den_ff <= g_rd_ff - g_lo_ff;
            rem_ff <= {1'b0, item_ff.electron_energy - g_lo_ff};
         end
         w_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[32] || rem_ff[31]) begin
            rem_ff <= {1'b0, trial[31:0]};
            w_ff <= {w_ff[14:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], 1'b0};
            w_ff <= {w_ff[14:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.proc_start) begin
         p_ff <= '0;
         sum_ff <= '0;
         done_ff <= 1'b0;
         res_ff <= '{selected_process: 5'd0, null_collision: 1'b1};
         rd_ok_ff <= 1'b0;
      end
      if (cmd.proc_rd) begin
         prd_ff <= paddr;
         rd_ok_ff <= p_ff < n_eff;
         p_ff <= p_ff + PC'(1);
      end
      if (cmd.proc_acc) begin
         if (rd_ok_ff && !done_ff) begin
            sum_ff <= sum_in;
            if (sum_in > 64'(item_ff.random_draw)) begin
               done_ff <= 1'b1;
               res_ff <= '{selected_process: 5'(prd_ff), null_collision: 1'b0};
            end
         end
         if (!rd_ok_ff) done_ff <= 1'b1;
      end
   end

   assign sts.below = item_ff.electron_energy <= g_first_ff;
   assign sts.above = item_ff.electron_energy >= g_last_ff;
   assign sts.grid_found = item_ff.electron_energy < g_rd_ff;
   assign sts.div_last = dcnt_ff == 5'd15;
   assign sts.proc_done = done_ff;
   assign result = res_ff;
endmodule

// File: rtl/iwcs_control.sv
`timescale 1ns / 1ps
module iwcs_control import iwcs_pkg::*; #(
   parameter int GRID_POINTS = GRID_POINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic [1:0] req_op,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam int GW = $clog2(GRID_POINTS);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GRID = 3'd1;
   localparam logic [2:0] S_DIVS = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_PRD = 3'd4;
   localparam logic [2:0] S_PACC = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [GW:0] cnt_ff, cnt_in;
   logic       found_ff, found_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      found_in = found_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_SAMPLE) begin
                  cmd.start = 1'b1;
                  state_in = S_GRID;
                  cnt_in = '0;
                  found_in = 1'b0;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_GRID: begin
            cmd.grid_rd = 1'b1;
            if (found_ff || sts.grid_found || cnt_ff == (GW+1)'(GRID_POINTS - 2)) begin
               state_in = S_DIVS;
            end else begin
               cmd.grid_step = 1'b1;
               cnt_in = cnt_ff + (GW+1)'(1);
            end
            if (sts.grid_found) found_in = 1'b1;
         end
         S_DIVS: begin
            if (cnt_ff == (GW+1)'(GRID_POINTS - 2) && !found_ff && !sts.grid_found) begin
               cmd.grid_rd = 1'b1;
               cmd.grid_step = 1'b1;
               cnt_in = cnt_ff + (GW+1)'(1);
               found_in = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.proc_start = 1'b1;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            cmd.proc_rd = 1'b1;
            state_in = S_PACC;
         end
         S_PACC: begin
            cmd.proc_acc = 1'b1;
            state_in = S_PRD;
            if (sts.proc_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         found_ff <= found_in;
      end
   end
endmodule

// File: tb/interp_weighted_collision_select_tb.sv
`timescale 1ns / 1ps
module interp_weighted_collision_select_tb;
   import iwcs_pkg::*;

   localparam int POINTS = GRID_POINTS_DEF;
   localparam int PROCS = MAX_PROCESSES_DEF;
   localparam int BAND_LO = 96;
   localparam int BAND_HI = 111;

   class collision_scoreboard;
      logic [31:0] freq_table[POINTS * PROCS];
      bit freq_set[POINTS * PROCS];
      logic [31:0] grid[POINTS];
      logic [31:0] thresh[PROCS];
      int unsigned active_count;
      rsp_type expected_q[$];
      int errors;

      function new();
         active_count = 1;
         errors = 0;
      endfunction

      function void set_active(logic [5:0] v);
         active_count = (v > PROCS) ? PROCS : v;
      endfunction

      function bit covered(logic [31:0] en);
         int unsigned lo, hi;
         lo = 0;
         hi = 0;
         if (en <= grid[0]) begin
            lo = 0;
            hi = 0;
         end else if (en >= grid[POINTS - 1]) begin
            lo = POINTS - 1;
            hi = POINTS - 1;
         end else begin
            while (lo < POINTS - 2 && !(en < grid[lo + 1])) lo++;
            hi = lo + 1;
         end
         for (int p = 0; p < PROCS; p++)
            if (!freq_set[lo * PROCS + p] || !freq_set[hi * PROCS + p]) return 1'b0;
         return 1'b1;
      endfunction

      function rsp_type select_process(req_type r);
         rsp_type res;
         int unsigned lo, hi, p;
         logic [63:0] num, den, w, sum, f_lo, f_hi;
         lo = 0;
         hi = 0;
         w = 0;
         if (r.electron_energy <= grid[0]) begin
            lo = 0;
            hi = 0;
         end else if (r.electron_energy >= grid[POINTS - 1]) begin
            lo = POINTS - 1;
            hi = POINTS - 1;
         end else begin
            while (lo < POINTS - 2 && !(r.electron_energy < grid[lo + 1])) lo++;
            hi = lo + 1;
            num = 64'(r.electron_energy - grid[lo]);
            den = 64'(grid[hi] - grid[lo]);
            w = (den != 0) ? ((num << 16) / den) : 0;
            if (w > 65535) w = 65535;
         end
         sum = 0;
         res.selected_process = '0;
         res.null_collision = 1'b1;
         for (p = 0; p < active_count; p++) begin
            if (thresh[p] <= r.electron_energy) begin
               f_lo = 64'(freq_table[lo * PROCS + p]);
               f_hi = 64'(freq_table[hi * PROCS + p]);
               sum += ((f_lo * (65536 - w) + f_hi * w) >> 16);
            end
            if (sum > 64'(r.random_draw)) begin
               res.selected_process = p[4:0];
               res.null_collision = 1'b0;
               return res;
            end
         end
         return res;
      endfunction

      function void note_request(req_type r);
         case (r.operation)
            OP_LOAD_FREQ: begin
               freq_table[r.point_index * PROCS + r.process_index] = r.table_word;
               freq_set[r.point_index * PROCS + r.process_index] = 1'b1;
            end
            OP_LOAD_ENERGY: grid[r.point_index] = r.table_word;
            OP_LOAD_THRESH: thresh[r.process_index] = r.table_word;
            default: expected_q.push_back(select_process(r));
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("unexpected response transaction: process %0d null %0b",
                   got.selected_process, got.null_collision);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (got.selected_process !== exp_rsp.selected_process) begin
            $error("selected_process: expected %0d actual %0d",
                   exp_rsp.selected_process, got.selected_process);
            errors++;
         end
         if (got.null_collision !== exp_rsp.null_collision) begin
            $error("null_collision: expected %0b actual %0b",
                   exp_rsp.null_collision, got.null_collision);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [5:0] csr_data;

   collision_scoreboard sb;
   int accepted;
   bit steady;
   bit hold_done;

   interp_weighted_collision_select uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("interp_weighted_collision_select_tb: FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   initial begin
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (!hold_done && accepted > 1000) begin
            hold_done = 1;
            rsp_stall <= 1'b1;
            repeat (1500) @(negedge clock);
         end
         rsp_stall <= (pick_gap() != 0);
         @(negedge clock);
      end
   end

   task automatic send_item(req_type r);
      int g;
      g = pick_gap();
      @(negedge clock);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      accepted++;
      if (accepted % 97 == 0) steady = ~steady;
   endtask

   task automatic write_csr(logic [5:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_active(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic req_type load_item(logic [1:0] op, int pt, int pr, logic [31:0] word);
      req_type r;
      r.operation = op;
      r.electron_energy = $urandom;
      r.random_draw = $urandom;
      r.point_index = pt[7:0];
      r.process_index = pr[4:0];
      r.table_word = word;
      return r;
   endfunction

   function automatic req_type sample_item(logic [31:0] en, logic [31:0] draw);
      req_type r;
      r = load_item(OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 31), $urandom);
      r.electron_energy = en;
      r.random_draw = draw;
      return r;
   endfunction

   function automatic logic [31:0] grid_word(int pt);
      return (32'(pt) << 24) + $urandom_range(1, 32'h00FF_FFFF);
   endfunction

   function automatic logic [31:0] freq_word();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1 << 20) : $urandom;
   endfunction

   function automatic req_type random_item();
      int r, k, tries;
      logic [31:0] en, draw;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 255);
      if (r < 12) return load_item(OP_LOAD_FREQ, k, $urandom_range(0, 31), freq_word());
      if (r < 22) return load_item(OP_LOAD_ENERGY, k,
                                   $urandom_range(0, 31),
                                   ($urandom_range(0, 9) == 0) ? $urandom : grid_word(k));
      if (r < 30) return load_item(OP_LOAD_THRESH, k, $urandom_range(0, 31),
                                   ($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(0, 1 << 31));
      tries = 0;
      do begin
         k = $urandom_range(BAND_LO, BAND_HI);
         r = $urandom_range(0, 99);
         if (r < 40) en = $urandom;
         else if (r < 60) en = sb.grid[k];
         else if (r < 80) en = sb.grid[k] + $urandom_range(0, 3) - 1;
         else if (r < 90) en = $urandom_range(0, sb.grid[0]);
         else en = 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
         tries++;
      end while (!sb.covered(en) && tries < 16);
      if (!sb.covered(en)) en = '0;
      r = $urandom_range(0, 99);
      if (r < 55) draw = $urandom_range(0, sb.active_count << 20);
      else if (r < 70) draw = '0;
      else draw = $urandom;
      return sample_item(en, draw);
   endfunction

   initial begin
      logic [5:0] phase_cfg[7];
      int i, j, ph;
      sb = new();
      accepted = 0;
      steady = 0;
      hold_done = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(6'd32);
      for (i = 0; i < POINTS; i++) send_item(load_item(OP_LOAD_ENERGY, i, 0, grid_word(i)));
      for (j = 0; j < PROCS; j++)
         send_item(load_item(OP_LOAD_THRESH, 0, j, $urandom_range(0, 1 << 31)));
      for (i = 0; i < POINTS; i++)
         if (i == 0 || i == POINTS - 1 || (i >= BAND_LO && i <= BAND_HI))
            for (j = 0; j < PROCS; j++) send_item(load_item(OP_LOAD_FREQ, i, j, freq_word()));

      send_item(load_item(OP_LOAD_THRESH, 0, 0, 32'hFFFF_FFFF));
      send_item(load_item(OP_LOAD_THRESH, 0, 1, 32'h0));
      send_item(load_item(OP_LOAD_FREQ, 255, 31, 32'hFFFF_FFFF));
      send_item(sample_item(32'h0, 32'h0));
      send_item(sample_item(sb.grid[0], 32'hFFFF_FFFF));
      send_item(sample_item(sb.grid[BAND_LO] + 1, 32'h0000_1000));
      send_item(sample_item(sb.grid[100], 32'h0010_0000));
      send_item(sample_item(sb.grid[100] + 1, 32'h0));
      send_item(sample_item(sb.grid[BAND_HI - 1], 32'h0020_0000));
      send_item(sample_item(sb.grid[255], 32'h0));
      send_item(sample_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(sample_item(32'hFFFF_FFFF, 32'h0));
      send_item(sample_item(32'h6800_0000, 32'h7FFF_FFFF));
      drain();
      write_csr(6'd0);
      send_item(sample_item(32'h6800_0000, 32'h0));
      send_item(sample_item(32'hFFFF_FFFF, 32'h0));
      drain();
      write_csr(6'd63);
      send_item(sample_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(sample_item(32'h6400_0000, 32'h0));

      phase_cfg = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd17, 6'd31};
      for (ph = 0; ph < 7; ph++) begin
         drain();
         write_csr(phase_cfg[ph]);
         for (i = 0; i < 95; i++) send_item(random_item());
      end
      @(negedge clock);
      req_valid <= 1'b0;
      drain();
      if (sb.errors == 0) begin
         $display("interp_weighted_collision_select_tb: PASS");
      end else begin
         $display("interp_weighted_collision_select_tb: FAIL");
      end
      $finish;
   end
endmodule
